>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SWM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/swm_pkg.sv
`default_nettype none
package swm_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int WINDOW_LEN = 5;
	localparam int MEDIAN_IDX = WINDOW_LEN / 2;
	localparam int AGE_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(WINDOW_LEN - 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [AGE_W-1:0] age_t;

	// Entry handed down from the upper neighbor.
	typedef struct packed {
		logic    valid;
		sample_t value;
		age_t    age;
	} entry_t;

	// Link handed up from the lower neighbor: removal prefix, compare flag
	// and the compacted entry of that position.
	typedef struct packed {
		logic    rem;
		logic    gt;
		sample_t c_value;
		age_t    c_age;
	} link_t;

	typedef struct packed {
		logic is_old;
		logic order_ok;
	} cell_status_t;

	typedef struct packed {
		logic [WINDOW_LEN-1:0] old_hits;
		logic                  sorted;
	} chain_status_t;

endpackage
`default_nettype wire

>>> src/swm_stream_if.sv
`default_nettype none
interface swm_sample_if;
	logic              valid;
	logic              ready;
	swm_pkg::sample_t  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
	logic              valid;
	logic              ready;
	swm_pkg::sample_t  median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface
`default_nettype wire

>>> src/swm_cell.sv
`default_nettype none
module swm_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire swm_pkg::sample_t       x,
	input  wire swm_pkg::age_t          reset_age,
	input  wire swm_pkg::link_t         lower,
	input  wire swm_pkg::entry_t        upper,
	output swm_pkg::link_t              link_up,
	output swm_pkg::entry_t             entry_down,
	output swm_pkg::sample_t            nxt_value,
	output swm_pkg::cell_status_t       status
);

	swm_pkg::sample_t value_q;
	swm_pkg::age_t    age_q;

	logic             is_old;
	logic             rem;
	logic             has_c;
	logic             gt;
	swm_pkg::sample_t c_value;
	swm_pkg::age_t    c_age;
	swm_pkg::age_t    nxt_age;

	always_comb begin
		is_old  = (age_q == swm_pkg::OLDEST_AGE);
		rem     = lower.rem | is_old;
		// Close the gap left by the oldest entry: take the upper neighbor.
		has_c   = !rem || upper.valid;
		c_value = rem ? upper.value : value_q;
		c_age   = rem ? upper.age : age_q;
		gt      = !has_c || (c_value > x);

		if (!gt) begin
			nxt_value = c_value;
			nxt_age   = swm_pkg::age_t'(c_age + 1'b1);
		end else if (!lower.gt) begin
			nxt_value = x;
			nxt_age   = '0;
		end else begin
			nxt_value = lower.c_value;
			nxt_age   = swm_pkg::age_t'(lower.c_age + 1'b1);
		end

		link_up.rem     = rem;
		link_up.gt      = gt;
		link_up.c_value = c_value;
		link_up.c_age   = c_age;

		entry_down.valid = 1'b1;
		entry_down.value = value_q;
		entry_down.age   = age_q;

		status.is_old   = is_old;
		status.order_ok = !upper.valid || (value_q <= upper.value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			age_q   <= reset_age;
		end else if (en) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

endmodule
`default_nettype wire

>>> src/swm_chain.sv
`default_nettype none
module swm_chain (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire swm_pkg::sample_t  x,
	output swm_pkg::sample_t       median_next,
	output swm_pkg::chain_status_t status
);

	localparam int N = swm_pkg::WINDOW_LEN;

	swm_pkg::link_t        links   [0:N];
	swm_pkg::entry_t       entries [0:N];
	swm_pkg::sample_t      nxt     [0:N-1];
	swm_pkg::cell_status_t cst     [0:N-1];
	logic [N-1:0]          order_ok;

	// Bottom of the row: nothing removed below, never greater than x.
	assign links[0] = '{rem: 1'b0, gt: 1'b0, c_value: '0, c_age: '0};
	// Top of the row: no upper neighbor.
	assign entries[N] = '{valid: 1'b0, value: '0, age: '0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		swm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.x          (x),
			.reset_age  (swm_pkg::age_t'(i)),
			.lower      (links[i]),
			.upper      (entries[i+1]),
			.link_up    (links[i+1]),
			.entry_down (entries[i]),
			.nxt_value  (nxt[i]),
			.status     (cst[i])
		);
		assign status.old_hits[i] = cst[i].is_old;
		assign order_ok[i]        = cst[i].order_ok;
	end

	assign status.sorted = &order_ok;

	assign median_next = nxt[swm_pkg::MEDIAN_IDX];

endmodule
`default_nettype wire

>>> src/sliding_window_median.sv
// Channel     Dir  Payload          Handshake
// sample_ch   in   sample  [23:0]s  valid/ready
// median_ch   out  median  [23:0]s  valid/ready
//
// One sample per cycle while sample_ch is ready; the median of the updated
// window appears in the cycle after the beat is taken. It is registered from
// the sorted cell row, where the removal flag ripples across all cells.
// Reset zeroes the window and sets distinct ages; no clearing pass.
// Input is held off only while a result waits and median_ch is not ready.
`default_nettype none
module sliding_window_median (
	input  wire logic     clk,
	input  wire logic     arst_n,
	swm_sample_if.sink    sample_ch,
	swm_median_if.source  median_ch
);

`include "assert_macros.svh"

	logic                   accept;
	logic                   out_valid_q;
	swm_pkg::sample_t       median_q;
	swm_pkg::sample_t       median_next;
	swm_pkg::chain_status_t chain_status;

	assign sample_ch.ready = !out_valid_q || median_ch.ready;
	assign accept          = sample_ch.valid && sample_ch.ready;

	swm_chain u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.x           (sample_ch.sample),
		.median_next (median_next),
		.status      (chain_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (median_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			median_q <= median_next;
		end
	end

	assign median_ch.valid  = out_valid_q;
	assign median_ch.median = median_q;

	`SWM_ASSERT_ALWAYS(a_one_oldest, clk, arst_n, $onehot(chain_status.old_hits), "oldest entry not unique")
	`SWM_ASSERT_ALWAYS(a_row_sorted, clk, arst_n, chain_status.sorted, "cell row out of order")
	`SWM_ASSERT_NEXT(a_result_follows, clk, arst_n, accept, median_ch.valid, "no result after beat")

endmodule
`default_nettype wire
